>>> hw/rtl/ircut_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ircut_pkg;

  // Default widths for the parameters of the top level.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PULSE_BITS_DEF  = 16;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes, one 32-bit word apart.
  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_THRESHOLD  = 3'd1,
    REG_HYSTERESIS = 3'd2,
    REG_BRIGHTNESS = 3'd3,
    REG_SENSOR     = 3'd4,
    REG_PULSE      = 3'd5,
    REG_DEBOUNCE   = 3'd6
  } reg_idx_t;

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TICK    = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_DISABLE = 2'd3
  } op_t;

  // Mode register codes. The fourth code selects nothing.
  localparam logic [1:0] MODE_FORCE_ON  = 2'd0;
  localparam logic [1:0] MODE_FORCE_OFF = 2'd1;
  localparam logic [1:0] MODE_AUTO      = 2'd2;

  // Register reset values.
  localparam logic [1:0]  MODE_RST       = MODE_AUTO;
  localparam logic [15:0] THRESHOLD_RST  = 16'd100;
  localparam logic [15:0] HYSTERESIS_RST = 16'd10;
  localparam logic [7:0]  BRIGHTNESS_RST = 8'd255;
  localparam logic        SENSOR_RST     = 1'b0;
  localparam logic [15:0] PULSE_RST      = 16'd50;
  localparam logic [3:0]  DEBOUNCE_RST   = 4'd3;

  // Output item width: 13 bits of fields, padded to two bytes.
  localparam int RES_W = 16;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] threshold;
    logic [15:0] hysteresis;
    logic [7:0]  brightness;
    logic        sensor_present;
    logic [15:0] pulse_ticks;
    logic [3:0]  debounce_needed;
  } cfg_t;

  typedef struct packed {
    logic       switched;
    logic       night_state;
    logic [7:0] led_level;
    logic       led_enable;
    logic       coil_neg;
    logic       coil_pos;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/ircut_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ircut_ctrl import ircut_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int PULSE_BITS  = PULSE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   fire,
  input  wire op_t                    op,
  input  wire logic [SAMPLE_BITS-1:0] light_level,
  input  wire cfg_t                   cfg,
  output res_t                        res_next
);

  // Compare width covers a sample plus a 16-bit margin without overflow.
  localparam int CMP_W = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;

  logic                  night_flag;
  logic [3:0]            debounce_count;
  logic                  enabled_flag;
  logic                  sampling_active;
  logic [PULSE_BITS-1:0] pulse_remaining;
  logic                  coil_pos_reg;
  logic                  coil_neg_reg;
  logic                  led_reg;

  logic                  night_flag_next;
  logic [3:0]            debounce_count_next;
  logic                  enabled_flag_next;
  logic                  sampling_active_next;
  logic [PULSE_BITS-1:0] pulse_remaining_next;
  logic                  coil_pos_next;
  logic                  coil_neg_next;
  logic                  led_next;
  logic                  switched;

  logic [CMP_W-1:0]      level_ext;
  logic [CMP_W-1:0]      thr_ext;
  logic [CMP_W-1:0]      hys_ext;
  logic                  qualifies;
  logic [3:0]            count_inc;
  logic [PULSE_BITS-1:0] pulse_dec;

  // Hysteresis comparison on the side opposite to the current state.
  assign level_ext = CMP_W'(light_level);
  assign thr_ext   = CMP_W'(cfg.threshold);
  assign hys_ext   = CMP_W'(cfg.hysteresis);
  assign qualifies = night_flag ? (level_ext > thr_ext + hys_ext)
                                : (level_ext + hys_ext < thr_ext);
  assign count_inc = debounce_count + 4'd1;
  assign pulse_dec = (pulse_remaining != '0) ? pulse_remaining - PULSE_BITS'(1)
                                             : pulse_remaining;

  // Next state for the item being processed.
  always_comb begin
    night_flag_next      = night_flag;
    debounce_count_next  = debounce_count;
    enabled_flag_next    = enabled_flag;
    sampling_active_next = sampling_active;
    pulse_remaining_next = pulse_remaining;
    coil_pos_next        = coil_pos_reg;
    coil_neg_next        = coil_neg_reg;
    led_next             = led_reg;
    switched             = 1'b0;
    case (op)
      OP_SAMPLE: begin
        if (enabled_flag && sampling_active) begin
          if (qualifies) begin
            debounce_count_next = count_inc;
            if (count_inc >= cfg.debounce_needed) begin
              night_flag_next      = !night_flag;
              coil_pos_next        = !night_flag;
              coil_neg_next        = night_flag;
              led_next             = !night_flag;
              pulse_remaining_next = PULSE_BITS'(cfg.pulse_ticks);
              debounce_count_next  = 4'd0;
              switched             = 1'b1;
            end
          end else begin
            debounce_count_next = 4'd0;
          end
        end
      end
      OP_TICK: begin
        pulse_remaining_next = pulse_dec;
        if (pulse_dec == '0) begin
          coil_pos_next = 1'b0;
          coil_neg_next = 1'b0;
        end
      end
      OP_ENABLE: begin
        enabled_flag_next    = 1'b1;
        sampling_active_next = 1'b0;
        case (cfg.mode)
          MODE_FORCE_ON: begin
            night_flag_next      = 1'b1;
            coil_pos_next        = 1'b1;
            coil_neg_next        = 1'b0;
            led_next             = 1'b1;
            pulse_remaining_next = PULSE_BITS'(cfg.pulse_ticks);
            switched             = 1'b1;
          end
          MODE_FORCE_OFF: begin
            night_flag_next      = 1'b0;
            coil_pos_next        = 1'b0;
            coil_neg_next        = 1'b1;
            led_next             = 1'b0;
            pulse_remaining_next = PULSE_BITS'(cfg.pulse_ticks);
            switched             = 1'b1;
          end
          MODE_AUTO: begin
            sampling_active_next = cfg.sensor_present;
          end
          default: begin
            sampling_active_next = 1'b0;
          end
        endcase
      end
      default: begin
        // Disable stops everything and forces the filter off.
        enabled_flag_next    = 1'b0;
        sampling_active_next = 1'b0;
        night_flag_next      = 1'b0;
        coil_pos_next        = 1'b0;
        coil_neg_next        = 1'b1;
        led_next             = 1'b0;
        pulse_remaining_next = PULSE_BITS'(cfg.pulse_ticks);
        switched             = 1'b1;
      end
    endcase
  end

  // Result fields show the state after the item.
  always_comb begin
    res_next.coil_pos    = coil_pos_next;
    res_next.coil_neg    = coil_neg_next;
    res_next.led_enable  = led_next;
    res_next.led_level   = cfg.brightness;
    res_next.night_state = night_flag_next;
    res_next.switched    = switched;
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      night_flag      <= 1'b0;
      debounce_count  <= 4'd0;
      enabled_flag    <= 1'b0;
      sampling_active <= 1'b0;
      pulse_remaining <= '0;
      coil_pos_reg    <= 1'b0;
      coil_neg_reg    <= 1'b0;
      led_reg         <= 1'b0;
    end else if (fire) begin
      night_flag      <= night_flag_next;
      debounce_count  <= debounce_count_next;
      enabled_flag    <= enabled_flag_next;
      sampling_active <= sampling_active_next;
      pulse_remaining <= pulse_remaining_next;
      coil_pos_reg    <= coil_pos_next;
      coil_neg_reg    <= coil_neg_next;
      led_reg         <= led_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ircut_day_night_switch_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Day/night switch for an IR-cut filter with an IR LED.
// Input stream (s_*): one item per transfer, opcode in tdata[1:0] (sample,
// tick, enable, disable) and the light level above it. Output stream (m_*):
// one result per input item, in order, with the coil drives, LED enable and
// level, the filter state and a flag that marks a switch.
// Configuration goes through the APB port, one register per 32-bit word;
// the user must write registers only while no item is in flight, as the
// block itself does not enforce it. An accepted item waits in the input
// register; when it fires, the decision logic updates the state and loads
// the result register. Throughput is one item per cycle while the receiver
// takes results; the next state is computed combinationally from the state
// registers, so dependent items can follow back to back.
// When the receiver stalls, the result register holds its value, the input
// register fills, and s_tready drops until the result is taken.
// Reset clears both stream registers, the filter state and the countdown,
// and loads every configuration register with its reset value.

module ircut_day_night_switch_top import ircut_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int PULSE_BITS  = PULSE_BITS_DEF,
  localparam int IN_W       = ((2 + SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input stream. tdata: opcode[1:0], light_level[SAMPLE_BITS+1:2], zero pad.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_W-1:0]       s_tdata,
  // Output stream. tdata: coil_pos, coil_neg, led_enable, led_level[10:3],
  // night_state[11], switched[12], zero pad.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [RES_W-1:0]           m_tdata,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  cfg_t                   cfg;
  logic                   cfg_write;
  reg_idx_t               cfg_idx;

  logic                   in_valid;
  op_t                    in_op;
  logic [SAMPLE_BITS-1:0] in_level;
  logic                   fire;
  res_t                   res_next;
  res_t                   res;

  // Register file.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= MODE_RST;
      cfg.threshold       <= THRESHOLD_RST;
      cfg.hysteresis      <= HYSTERESIS_RST;
      cfg.brightness      <= BRIGHTNESS_RST;
      cfg.sensor_present  <= SENSOR_RST;
      cfg.pulse_ticks     <= PULSE_RST;
      cfg.debounce_needed <= DEBOUNCE_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_MODE:       cfg.mode            <= pwdata[1:0];
        REG_THRESHOLD:  cfg.threshold       <= pwdata[15:0];
        REG_HYSTERESIS: cfg.hysteresis      <= pwdata[15:0];
        REG_BRIGHTNESS: cfg.brightness      <= pwdata[7:0];
        REG_SENSOR:     cfg.sensor_present  <= pwdata[0];
        REG_PULSE:      cfg.pulse_ticks     <= pwdata[15:0];
        REG_DEBOUNCE:   cfg.debounce_needed <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_idx)
      REG_MODE:       prdata = CFG_DATA_W'(cfg.mode);
      REG_THRESHOLD:  prdata = CFG_DATA_W'(cfg.threshold);
      REG_HYSTERESIS: prdata = CFG_DATA_W'(cfg.hysteresis);
      REG_BRIGHTNESS: prdata = CFG_DATA_W'(cfg.brightness);
      REG_SENSOR:     prdata = CFG_DATA_W'(cfg.sensor_present);
      REG_PULSE:      prdata = CFG_DATA_W'(cfg.pulse_ticks);
      REG_DEBOUNCE:   prdata = CFG_DATA_W'(cfg.debounce_needed);
      default:        prdata = '0;
    endcase
  end

  // An item is processed when the input register holds one and the result
  // register is free or being emptied in the same cycle.
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op    <= op_t'(s_tdata[1:0]);
      in_level <= s_tdata[SAMPLE_BITS+1:2];
    end
  end

  ircut_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PULSE_BITS  (PULSE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .op          (in_op),
    .light_level (in_level),
    .cfg         (cfg),
    .res_next    (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign m_tdata = RES_W'(res);

endmodule

`default_nettype wire

>>> hw/rtl/ircut_day_night_switch_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module ircut_day_night_switch_chk import ircut_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [RES_W-1:0] m_tdata
);

  // A stalled result keeps its value until the transfer completes.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset leaves the output stream empty.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // The two coil drives are never active together, and the LED follows the state.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && (m_tdata[2] == m_tdata[11]))
    else $error("coil or LED drive inconsistent with filter state");

  // A switch drives the coil that matches the new state.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> (m_tdata[0] == m_tdata[11]) && (m_tdata[1] != m_tdata[11]))
    else $error("switch without matching coil drive");

endmodule

bind ircut_day_night_switch_top ircut_day_night_switch_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import ircut_pkg::*;

  localparam int DATA_IN_W   = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 4;

  // The mode register has one code that selects nothing.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_IN_W-1:0]  s_tdata = '0;  // opcode[1:0], light_level[17:2], zero pad
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [RES_W-1:0]      m_tdata;       // coil_pos, coil_neg, led_enable, led_level[10:3],
                                        // night_state[11], switched[12], zero pad
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ircut_day_night_switch_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the registers and of the filter state.
  cfg_t cfg_shadow = '{mode: MODE_RST, threshold: THRESHOLD_RST, hysteresis: HYSTERESIS_RST,
                       brightness: BRIGHTNESS_RST, sensor_present: SENSOR_RST,
                       pulse_ticks: PULSE_RST, debounce_needed: DEBOUNCE_RST};
  logic        is_night    = 1'b0;
  logic [3:0]  qual_count  = 4'd0;
  logic        ctrl_on     = 1'b0;
  logic        is_sampling = 1'b0;
  logic [15:0] pulse_left  = 16'd0;
  logic        coil_pos_q  = 1'b0;
  logic        coil_neg_q  = 1'b0;
  logic        led_on      = 1'b0;

  res_t filter_results_q[$];
  int   err_count      = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_start     = 1'b0;
  int   hold_left      = 0;
  int   stall_cycles   = 0;

  // Commands the motor toward one state and restarts the coil pulse.
  function automatic void drive_filter(logic night);
    is_night   = night;
    coil_pos_q = night;
    coil_neg_q = !night;
    led_on     = night;
    pulse_left = cfg_shadow.pulse_ticks;
  endfunction

  // Applies one item to the shadow state and returns the result it produces.
  function automatic res_t predict_filter_state(op_t op, logic [15:0] lvl);
    res_t r;
    logic qualifies;
    r = '0;
    case (op)
      OP_SAMPLE: begin
        if (ctrl_on && is_sampling) begin
          if (is_night)
            qualifies = {1'b0, lvl} > ({1'b0, cfg_shadow.threshold} +
                                       {1'b0, cfg_shadow.hysteresis});
          else
            qualifies = ({1'b0, lvl} + {1'b0, cfg_shadow.hysteresis}) <
                        {1'b0, cfg_shadow.threshold};
          if (qualifies) begin
            qual_count = qual_count + 4'd1;
            if (qual_count >= cfg_shadow.debounce_needed) begin
              drive_filter(!is_night);
              qual_count = 4'd0;
              r.switched = 1'b1;
            end
          end else begin
            qual_count = 4'd0;
          end
        end
      end
      OP_TICK: begin
        if (pulse_left != 16'd0) pulse_left = pulse_left - 16'd1;
        if (pulse_left == 16'd0) begin
          coil_pos_q = 1'b0;
          coil_neg_q = 1'b0;
        end
      end
      OP_ENABLE: begin
        ctrl_on     = 1'b1;
        is_sampling = 1'b0;
        if (cfg_shadow.mode == MODE_FORCE_ON) begin
          drive_filter(1'b1);
          r.switched = 1'b1;
        end else if (cfg_shadow.mode == MODE_FORCE_OFF) begin
          drive_filter(1'b0);
          r.switched = 1'b1;
        end else if (cfg_shadow.mode == MODE_AUTO) begin
          is_sampling = cfg_shadow.sensor_present;
        end
      end
      default: begin
        ctrl_on     = 1'b0;
        is_sampling = 1'b0;
        drive_filter(1'b0);
        r.switched = 1'b1;
      end
    endcase
    r.coil_pos    = coil_pos_q;
    r.coil_neg    = coil_neg_q;
    r.led_enable  = led_on;
    r.led_level   = cfg_shadow.brightness;
    r.night_state = is_night;
    return r;
  endfunction

  // Offers one item after a random gap and records its expected result on transfer.
  task automatic send_item(op_t op, logic [15:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, lvl, op};
    do @(posedge clk); while (!s_tready);
    filter_results_q.push_back(predict_filter_state(op, lvl));
  endtask

  // Stops the input stream and waits until every result has come out.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (filter_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:       cfg_shadow.mode            = value[1:0];
      REG_THRESHOLD:  cfg_shadow.threshold       = value[15:0];
      REG_HYSTERESIS: cfg_shadow.hysteresis      = value[15:0];
      REG_BRIGHTNESS: cfg_shadow.brightness      = value[7:0];
      REG_SENSOR:     cfg_shadow.sensor_present  = value[0];
      REG_PULSE:      cfg_shadow.pulse_ticks     = value[15:0];
      REG_DEBOUNCE:   cfg_shadow.debounce_needed = value[3:0];
      default: ;
    endcase
  endtask

  // Picks an extreme now and then, otherwise a typical value.
  function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi,
                                             logic [31:0] typical);
    int r;
    r = $urandom_range(99);
    if (r < 15) return lo;
    if (r < 30) return hi;
    return typical;
  endfunction

  // Nothing enabled after reset, and no sensor: samples are ignored until a disable.
  task automatic test_after_reset();
    send_item(OP_TICK, 16'd0);
    send_item(OP_SAMPLE, 16'd0);
    send_item(OP_ENABLE, 16'hFFFF);
    send_item(OP_SAMPLE, 16'd0);
    send_item(OP_DISABLE, 16'h5555);
  endtask

  // Forced modes, including a forced switch to the current state and the unused code.
  task automatic test_forced_modes();
    wait_idle();
    apb_write(REG_MODE, 32'(MODE_FORCE_ON));
    send_item(OP_ENABLE, 16'd0);
    send_item(OP_ENABLE, 16'hAAAA);
    wait_idle();
    apb_write(REG_MODE, 32'(MODE_FORCE_OFF));
    send_item(OP_ENABLE, 16'd0);
    wait_idle();
    apb_write(REG_MODE, 32'(MODE_UNUSED));
    send_item(OP_ENABLE, 16'd0);
  endtask

  // Debounce in automatic mode: a non-qualifying sample clears the count.
  task automatic test_auto_debounce();
    wait_idle();
    apb_write(REG_MODE, 32'(MODE_AUTO));
    apb_write(REG_SENSOR, 32'd1);
    apb_write(REG_THRESHOLD, 32'd1000);
    apb_write(REG_HYSTERESIS, 32'd100);
    apb_write(REG_DEBOUNCE, 32'd3);
    apb_write(REG_PULSE, 32'd2);
    apb_write(REG_BRIGHTNESS, 32'h5A);
    send_item(OP_ENABLE, 16'd0);
    send_item(OP_SAMPLE, 16'd899);
    send_item(OP_SAMPLE, 16'd900);
    send_item(OP_SAMPLE, 16'd0);
    send_item(OP_SAMPLE, 16'd899);
    send_item(OP_SAMPLE, 16'd0);
    send_item(OP_TICK, 16'd0);
    send_item(OP_TICK, 16'd0);
    send_item(OP_SAMPLE, 16'd1100);
    repeat (3) send_item(OP_SAMPLE, 16'hFFFF);
  endtask

  // Zero pulse, zero debounce limit, and a threshold below the hysteresis.
  task automatic test_limit_settings();
    wait_idle();
    apb_write(REG_PULSE, 32'd0);
    apb_write(REG_DEBOUNCE, 32'd0);
    apb_write(REG_THRESHOLD, 32'd5);
    apb_write(REG_HYSTERESIS, 32'd10);
    apb_write(REG_BRIGHTNESS, 32'd0);
    send_item(OP_SAMPLE, 16'd0);
    wait_idle();
    apb_write(REG_THRESHOLD, 32'hFFFF);
    apb_write(REG_HYSTERESIS, 32'd0);
    send_item(OP_SAMPLE, 16'd0);
    send_item(OP_TICK, 16'd0);
    send_item(OP_SAMPLE, 16'hFFFF);
  endtask

  // Random item, biased toward samples that push the filter to the other state.
  task automatic send_random_item();
    int          pick;
    op_t         op;
    logic [16:0] upper;
    logic [15:0] thr;
    logic [15:0] hyst;
    logic [15:0] lvl;
    pick  = $urandom_range(99);
    thr   = cfg_shadow.threshold;
    hyst  = cfg_shadow.hysteresis;
    upper = {1'b0, thr} + {1'b0, hyst};
    lvl   = 16'($urandom());
    if (pick < 6) begin
      op = OP_ENABLE;
    end else if (pick < 8) begin
      op = OP_DISABLE;
    end else if (pick < 28) begin
      op = OP_TICK;
    end else begin
      op = OP_SAMPLE;
      if (pick < 78) begin
        if (is_night && upper < 17'd65535)
          lvl = 16'($urandom_range(65535, upper + 17'd1));
        else if (!is_night && thr > hyst)
          lvl = 16'($urandom_range(thr - hyst - 16'd1, 0));
      end else if (pick < 90) begin
        // Right at the edge of the qualifying band.
        if (is_night)
          lvl = (upper >= 17'd65535) ? 16'hFFFF : upper[15:0] + 16'($urandom_range(1));
        else if (thr > hyst)
          lvl = thr - hyst - 16'($urandom_range(1));
        else
          lvl = 16'($urandom_range(1));
      end
    end
    send_item(op, lvl);
  endtask

  // Writes every register with a fresh setting while the block is idle.
  task automatic randomize_config();
    int r;
    wait_idle();
    r = $urandom_range(9);
    apb_write(REG_MODE, 32'((r == 6) ? MODE_FORCE_ON : (r == 7) ? MODE_FORCE_OFF :
                            (r == 8) ? MODE_UNUSED : MODE_AUTO));
    apb_write(REG_THRESHOLD, pick_value(0, 32'hFFFF, $urandom_range(60000, 2000)));
    apb_write(REG_HYSTERESIS, pick_value(0, 32'hFFFF, $urandom_range(600, 0)));
    apb_write(REG_BRIGHTNESS, pick_value(0, 32'hFF, $urandom_range(255)));
    apb_write(REG_SENSOR, ($urandom_range(99) < 85) ? 32'd1 : 32'd0);
    apb_write(REG_PULSE, pick_value(0, 32'hFFFF, $urandom_range(6, 1)));
    apb_write(REG_DEBOUNCE, pick_value(0, 32'hF, $urandom_range(4, 1)));
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_start <= 1'b1;
    repeat (40) send_random_item();
    wait_idle();
  endtask

  // Random traffic under each idling pattern and several register settings.
  task automatic test_random_traffic();
    int idle_pat[4][2];
    idle_pat = '{'{0, 0}, '{82, 0}, '{0, 82}, '{12, 12}};
    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 4; c++) begin
        randomize_config();
        send_idle_pct  = idle_pat[p][0];
        recv_stall_pct = idle_pat[p][1];
        send_item(OP_ENABLE, 16'($urandom()));
        repeat (118) send_random_item();
      end
    end
  endtask

  // Receiver side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_start) begin
      hold_start <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    res_t exp_r;
    res_t got_r;
    if (!rst && m_tvalid && m_tready) begin
      got_r = m_tdata[$bits(res_t)-1:0];
      if (filter_results_q.size() == 0) begin
        $error("result transfer with no expected result pending: %h", m_tdata);
        err_count++;
      end else begin
        exp_r = filter_results_q.pop_front();
        if (got_r.coil_pos !== exp_r.coil_pos) begin
          $error("coil_pos: expected %0d, got %0d", exp_r.coil_pos, got_r.coil_pos);
          err_count++;
        end
        if (got_r.coil_neg !== exp_r.coil_neg) begin
          $error("coil_neg: expected %0d, got %0d", exp_r.coil_neg, got_r.coil_neg);
          err_count++;
        end
        if (got_r.led_enable !== exp_r.led_enable) begin
          $error("led_enable: expected %0d, got %0d", exp_r.led_enable, got_r.led_enable);
          err_count++;
        end
        if (got_r.led_level !== exp_r.led_level) begin
          $error("led_level: expected %0d, got %0d", exp_r.led_level, got_r.led_level);
          err_count++;
        end
        if (got_r.night_state !== exp_r.night_state) begin
          $error("night_state: expected %0d, got %0d", exp_r.night_state,
                 got_r.night_state);
          err_count++;
        end
        if (got_r.switched !== exp_r.switched) begin
          $error("switched: expected %0d, got %0d", exp_r.switched, got_r.switched);
          err_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without any stream transfer.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_forced_modes();
    test_auto_debounce();
    test_limit_settings();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
